@@ src/pttp_pkg.sv @@
// Shared types, widths and constants for the pan/tilt tracking PID unit.
// No dependencies; every other file imports this package.
package pttp_pkg;

	localparam int COORD_BITS     = 12;
	localparam int INTEGRAL_BITS  = 32;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int ANGLE_W        = 9;
	localparam int ANGLE_LIMIT    = 360;
	localparam int ANGLE_RESET    = 180;

	localparam int GAIN_W  = 16;
	localparam int DB_W    = 12;
	localparam int MODE_W  = 8;
	localparam int OP_W    = 2;
	localparam int ERR_W   = COORD_BITS + 2;
	localparam int DERIV_W = ERR_W + 1;

	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + INTEGRAL_BITS;
	localparam int PROD_D_W = GAIN_W + DERIV_W;
	localparam int SUM_W    = PROD_I_W + 1;
	localparam int SHIFT    = GAIN_FRAC_BITS + 1;
	localparam int DELTA_W  = SUM_W - SHIFT;
	localparam int STEP_W   = DELTA_W + 1;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [MODE_W-1:0] TRACK_MODE = MODE_W'(1);

	typedef logic [ANGLE_W-1:0]                angle_t;
	typedef logic [COORD_BITS-1:0]             coord_t;
	typedef logic signed [ERR_W-1:0]           err_t;
	typedef logic signed [INTEGRAL_BITS-1:0]   integ_t;
	typedef logic signed [DERIV_W-1:0]         deriv_t;

	typedef enum logic [OP_W-1:0] {
		OP_CENTER = 2'd0,
		OP_ANGLE  = 2'd1,
		OP_MODE   = 2'd2,
		OP_FRAME  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_KP_PAN   = 3'd0,
		REG_KI_PAN   = 3'd1,
		REG_KD_PAN   = 3'd2,
		REG_KP_TILT  = 3'd3,
		REG_KI_TILT  = 3'd4,
		REG_KD_TILT  = 3'd5,
		REG_DEADBAND = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gain_t;

	typedef struct packed {
		gain_t            pan;
		gain_t            tilt;
		logic [DB_W-1:0]  deadband;
	} cfg_t;

	// Per-lane control issued by the merge/control logic in the top level
	typedef struct packed {
		logic acc;         // input beat taken this cycle
		logic clr;         // clear integral and last error
		logic upd;         // advance integral and last error
		logic load2;       // stage 1 -> stage 2
		logic load3;       // stage 2 -> stage 3
		logic set_angle;   // stage 3 angle report retires
		logic step_angle;  // stage 3 PID step retires
	} lane_ctl_t;

endpackage

@@ src/pttp_if.sv @@
// Valid/ready channel interfaces for input events and angle commands.
// Depends on pttp_pkg.
interface pttp_item_if import pttp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	coord_t                pos_x;
	coord_t                pos_y;
	angle_t                pan_report;
	angle_t                tilt_report;
	logic [MODE_W-1:0]     new_mode;
	coord_t                frame_width;
	coord_t                frame_height;

	modport source (output valid, operation, pos_x, pos_y, pan_report, tilt_report,
		new_mode, frame_width, frame_height, input ready);
	modport sink (input valid, operation, pos_x, pos_y, pan_report, tilt_report,
		new_mode, frame_width, frame_height, output ready);
endinterface

interface pttp_result_if import pttp_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t pan_command;
	angle_t tilt_command;

	modport source (output valid, pan_command, tilt_command, input ready);
	modport sink (input valid, pan_command, tilt_command, output ready);
endinterface

@@ src/pttp_cfg.sv @@
// APB register file holding the PID gains and the deadband.
// Depends on pttp_pkg.
module pttp_cfg import pttp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan.kp   <= GAIN_W'(410);
			cfg_q.pan.ki   <= '0;
			cfg_q.pan.kd   <= '0;
			cfg_q.tilt.kp  <= GAIN_W'(410);
			cfg_q.tilt.ki  <= '0;
			cfg_q.tilt.kd  <= '0;
			cfg_q.deadband <= DB_W'(5);
		end else if (wr) begin
			unique case (idx)
				REG_KP_PAN:   cfg_q.pan.kp   <= pwdata[GAIN_W-1:0];
				REG_KI_PAN:   cfg_q.pan.ki   <= pwdata[GAIN_W-1:0];
				REG_KD_PAN:   cfg_q.pan.kd   <= pwdata[GAIN_W-1:0];
				REG_KP_TILT:  cfg_q.tilt.kp  <= pwdata[GAIN_W-1:0];
				REG_KI_TILT:  cfg_q.tilt.ki  <= pwdata[GAIN_W-1:0];
				REG_KD_TILT:  cfg_q.tilt.kd  <= pwdata[GAIN_W-1:0];
				REG_DEADBAND: cfg_q.deadband <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP_PAN:   prdata = APB_DW'(cfg_q.pan.kp);
			REG_KI_PAN:   prdata = APB_DW'(cfg_q.pan.ki);
			REG_KD_PAN:   prdata = APB_DW'(cfg_q.pan.kd);
			REG_KP_TILT:  prdata = APB_DW'(cfg_q.tilt.kp);
			REG_KI_TILT:  prdata = APB_DW'(cfg_q.tilt.ki);
			REG_KD_TILT:  prdata = APB_DW'(cfg_q.tilt.kd);
			REG_DEADBAND: prdata = APB_DW'(cfg_q.deadband);
			default:      prdata = '0;
		endcase
	end

endmodule

@@ src/pttp_lane.sv @@
// One axis of the controller: error, integral and derivative state,
// the three gain products, the scaled PID sum and the angle update.
// Depends on pttp_pkg.
module pttp_lane import pttp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  lane_ctl_t       ctl,
	input  gain_t           gain,
	input  coord_t          pos,
	input  coord_t          size,
	input  logic [DB_W-1:0] deadband,
	input  angle_t          report,
	output logic            centred,
	output angle_t          command
);

	integ_t integ_q;
	err_t   last_q;
	angle_t angle_q;

	err_t                       err;
	logic [ERR_W-1:0]           mag;
	logic signed [INTEGRAL_BITS:0] isum;
	integ_t                     integ_next;
	deriv_t                     deriv;

	err_t   err_s1;
	integ_t integ_s1;
	deriv_t deriv_s1;
	angle_t report_s1;

	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_I_W-1:0] prod_i_s2;
	logic signed [PROD_D_W-1:0] prod_d_s2;
	angle_t                     report_s2;

	logic signed [SUM_W-1:0]    neg_sum;
	logic signed [DELTA_W-1:0]  delta_s3;
	angle_t                     report_s3;
	logic signed [STEP_W-1:0]   step;

	// Error in half-pixels
	assign err     = $signed({1'b0, pos, 1'b0}) - $signed({2'b00, size});
	assign mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign centred = mag < {1'b0, deadband, 1'b0};

	assign isum  = $signed({integ_q[INTEGRAL_BITS-1], integ_q})
		+ $signed({{(INTEGRAL_BITS+1-ERR_W){err[ERR_W-1]}}, err});
	assign deriv = $signed({err[ERR_W-1], err}) - $signed({last_q[ERR_W-1], last_q});

	always_comb begin
		if (isum[INTEGRAL_BITS] != isum[INTEGRAL_BITS-1])
			integ_next = isum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
				: {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
		else
			integ_next = isum[INTEGRAL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctl.clr) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctl.upd) begin
			integ_q <= integ_next;
			last_q  <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			err_s1    <= err;
			integ_s1  <= integ_next;
			deriv_s1  <= deriv;
			report_s1 <= report;
		end
		if (ctl.load2) begin
			prod_p_s2 <= gain.kp * err_s1;
			prod_i_s2 <= gain.ki * integ_s1;
			prod_d_s2 <= gain.kd * deriv_s1;
			report_s2 <= report_s1;
		end
		if (ctl.load3) begin
			delta_s3  <= neg_sum[SUM_W-1:SHIFT];
			report_s3 <= report_s2;
		end
	end

	// Negated PID sum; the arithmetic shift floors the angle step
	assign neg_sum = -( $signed({{(SUM_W-PROD_P_W){prod_p_s2[PROD_P_W-1]}}, prod_p_s2})
		+ $signed({{(SUM_W-PROD_I_W){prod_i_s2[PROD_I_W-1]}}, prod_i_s2})
		+ $signed({{(SUM_W-PROD_D_W){prod_d_s2[PROD_D_W-1]}}, prod_d_s2}) );

	assign step = $signed({{(STEP_W-ANGLE_W){1'b0}}, angle_q})
		+ $signed({delta_s3[DELTA_W-1], delta_s3});

	always_comb begin
		if (step[STEP_W-1])
			command = '0;
		else if (step > $signed(STEP_W'(ANGLE_LIMIT)))
			command = ANGLE_W'(ANGLE_LIMIT);
		else
			command = step[ANGLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			angle_q <= ANGLE_W'(ANGLE_RESET);
		else if (ctl.set_angle)
			angle_q <= report_s3;
		else if (ctl.step_angle)
			angle_q <= command;
	end

endmodule

@@ src/pan_tilt_tracking_pid_unit.sv @@
// Two-axis pan/tilt tracking PID with deadband: top level, event decode,
// lane merge and output register. Depends on pttp_pkg, pttp_if, pttp_cfg, pttp_lane.
// A centre event's result passes the lane stage registers and then the output register.
// Throughput: one event per cycle unless stalled; angle_q feeds its own lane update.
// Reset (arst_n low): gains 410/0/0, deadband 5, mode 0, frame 0x0, angles 180,
// PID state cleared, pipeline and output register empty.
module pan_tilt_tracking_pid_unit import pttp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pttp_item_if.sink         item,
	pttp_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	logic [MODE_W-1:0] mode_q;
	coord_t            width_q;
	coord_t            height_q;

	logic v1_q, v2_q, v3_q;
	logic fire_s1, fire_s2, fire_s3;
	logic set_s1, set_s2, set_s3;

	logic   out_valid_q;
	angle_t pan_cmd_q;
	angle_t tilt_cmd_q;

	op_t       op;
	logic      acc, tracking, both_inside, take3;
	logic      inside_x, inside_y;
	angle_t    cmd_x, cmd_y;
	lane_ctl_t ctl;

	pttp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign op          = op_t'(item.operation);
	assign acc         = item.valid && item.ready;
	assign tracking    = (mode_q == TRACK_MODE) && (width_q != '0) && (height_q != '0);
	assign both_inside = inside_x && inside_y;

	// Stall chain: a stage moves on when the next one is empty or moving
	assign take3      = v3_q && (!fire_s3 || !out_valid_q || result.ready);
	assign ctl.load3  = v2_q && (!v3_q || take3);
	assign ctl.load2  = v1_q && (!v2_q || ctl.load3);
	assign item.ready = !v1_q || ctl.load2;

	assign ctl.acc = acc;
	assign ctl.clr = acc && ((op == OP_MODE && item.new_mode != mode_q)
		|| (op == OP_CENTER && tracking && both_inside));
	assign ctl.upd = acc && op == OP_CENTER && tracking && !both_inside;
	assign ctl.set_angle  = take3 && set_s3;
	assign ctl.step_angle = take3 && fire_s3;

	pttp_lane u_lane_pan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.gain     (cfg.pan),
		.pos      (item.pos_x),
		.size     (width_q),
		.deadband (cfg.deadband),
		.report   (item.pan_report),
		.centred  (inside_x),
		.command  (cmd_x)
	);

	pttp_lane u_lane_tilt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.gain     (cfg.tilt),
		.pos      (item.pos_y),
		.size     (height_q),
		.deadband (cfg.deadband),
		.report   (item.tilt_report),
		.centred  (inside_y),
		.command  (cmd_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (acc) begin
			case (op)
				OP_MODE: mode_q <= item.new_mode;
				OP_FRAME: begin
					width_q  <= item.frame_width;
					height_q <= item.frame_height;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			fire_s1 <= 1'b0;
			fire_s2 <= 1'b0;
			fire_s3 <= 1'b0;
			set_s1  <= 1'b0;
			set_s2  <= 1'b0;
			set_s3  <= 1'b0;
		end else begin
			if (acc) begin
				v1_q    <= 1'b1;
				fire_s1 <= ctl.upd;
				set_s1  <= op == OP_ANGLE;
			end else if (ctl.load2) begin
				v1_q <= 1'b0;
			end
			if (ctl.load2) begin
				v2_q    <= 1'b1;
				fire_s2 <= fire_s1;
				set_s2  <= set_s1;
			end else if (ctl.load3) begin
				v2_q <= 1'b0;
			end
			if (ctl.load3) begin
				v3_q    <= 1'b1;
				fire_s3 <= fire_s2;
				set_s3  <= set_s2;
			end else if (take3) begin
				v3_q <= 1'b0;
			end
		end
	end

	// Output register: hold the beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take3 && fire_s3)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take3 && fire_s3) begin
			pan_cmd_q  <= cmd_x;
			tilt_cmd_q <= cmd_y;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pan_command  = pan_cmd_q;
	assign result.tilt_command = tilt_cmd_q;

endmodule

@@ src/pttp_checker.sv @@
// Port-level checks on the result channel of the tracking PID unit.
// Depends on pttp_pkg; bound to pan_tilt_tracking_pid_unit below.
module pttp_checker import pttp_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_ready,
	input angle_t pan_command,
	input angle_t tilt_command
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pan_command) && $stable(tilt_command))
		else $error("result payload changed while stalled");

	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pan_command <= ANGLE_W'(ANGLE_LIMIT))
		else $error("pan command beyond angle limit");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tilt_command <= ANGLE_W'(ANGLE_LIMIT))
		else $error("tilt command beyond angle limit");

endmodule

bind pan_tilt_tracking_pid_unit pttp_checker u_pttp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.pan_command  (result.pan_command),
	.tilt_command (result.tilt_command)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for pan_tilt_tracking_pid_unit: drives centre, angle, mode and
// frame events with random gaps and back-pressure, and checks every angle command.
// Depends on pttp_pkg, pttp_if and the RTL of the unit.
module tb_top;
	import pttp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		op_t               op;
		coord_t            pos_x, pos_y;
		angle_t            pan, tilt;
		logic [MODE_W-1:0] mode;
		coord_t            fw, fh;
	} event_t;

	typedef struct {
		angle_t pan;
		angle_t tilt;
	} cmd_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pttp_item_if   item_ch();
	pttp_result_if result_ch();

	pan_tilt_tracking_pid_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the unit's registers and tracking state
	logic signed [GAIN_W-1:0] gain_q [6];
	logic [DB_W-1:0]          db_q;
	logic [MODE_W-1:0]        mode_q;
	angle_t                   pan_pos, tilt_pos;
	coord_t                   frame_w, frame_h;
	longint                   integ_x, integ_y, prev_err_x, prev_err_y;

	cmd_t        target_fifo [$];
	logic [15:0] cfg_stage [7];
	int          mismatches;
	int          cycle_count;
	bit          src_steady;
	bit          snk_steady;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pan_tilt_tracking_pid_unit: mismatch");
			$finish;
		end
	end

	task automatic clear_pid();
		integ_x = 0;
		integ_y = 0;
		prev_err_x = 0;
		prev_err_y = 0;
	endtask

	task automatic pid_axis(input longint err, inout longint integ, inout longint prev,
		input longint kp, input longint ki, input longint kd, inout angle_t angle);
		longint hi, deriv, sum, t;
		hi = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
		integ = integ + err;
		if (integ > hi)
			integ = hi;
		else if (integ < -hi - 1)
			integ = -hi - 1;
		deriv = err - prev;
		prev = err;
		sum = kp * err + ki * integ + kd * deriv;
		t = longint'(angle) * (longint'(1) << (GAIN_FRAC_BITS + 1)) - sum;
		// floor towards minus infinity: a negative target is clamped to zero anyway
		if (t < 0)
			angle = '0;
		else if ((t >>> (GAIN_FRAC_BITS + 1)) > ANGLE_LIMIT)
			angle = angle_t'(ANGLE_LIMIT);
		else
			angle = angle_t'(t >>> (GAIN_FRAC_BITS + 1));
	endtask

	task automatic track_event(input event_t ev);
		longint ex, ey, db2;
		cmd_t cmd;
		case (ev.op)
			OP_ANGLE: begin
				pan_pos = ev.pan;
				tilt_pos = ev.tilt;
			end
			OP_MODE: begin
				if (ev.mode != mode_q)
					clear_pid();
				mode_q = ev.mode;
			end
			OP_FRAME: begin
				frame_w = ev.fw;
				frame_h = ev.fh;
			end
			default: begin
				if (mode_q == TRACK_MODE && frame_w != 0 && frame_h != 0) begin
					ex = 2 * longint'(ev.pos_x) - longint'(frame_w);
					ey = 2 * longint'(ev.pos_y) - longint'(frame_h);
					db2 = 2 * longint'(db_q);
					if ((ex < 0 ? -ex : ex) < db2 && (ey < 0 ? -ey : ey) < db2) begin
						clear_pid();
					end else begin
						pid_axis(ex, integ_x, prev_err_x, gain_q[REG_KP_PAN],
							gain_q[REG_KI_PAN], gain_q[REG_KD_PAN], pan_pos);
						pid_axis(ey, integ_y, prev_err_y, gain_q[REG_KP_TILT],
							gain_q[REG_KI_TILT], gain_q[REG_KD_TILT], tilt_pos);
						cmd.pan = pan_pos;
						cmd.tilt = tilt_pos;
						target_fifo.push_back(cmd);
					end
				end
			end
		endcase
	endtask

	function automatic coord_t clip_coord(input int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return coord_t'(4095);
		return coord_t'(v);
	endfunction

	function automatic event_t mk_event(input op_t op, input int a, input int b);
		event_t ev;
		ev.op = op;
		ev.pos_x = coord_t'($urandom);
		ev.pos_y = coord_t'($urandom);
		ev.pan = angle_t'($urandom);
		ev.tilt = angle_t'($urandom);
		ev.mode = MODE_W'($urandom);
		ev.fw = coord_t'($urandom);
		ev.fh = coord_t'($urandom);
		case (op)
			OP_CENTER: begin ev.pos_x = coord_t'(a); ev.pos_y = coord_t'(b); end
			OP_ANGLE:  begin ev.pan = angle_t'(a); ev.tilt = angle_t'(b); end
			OP_MODE:   ev.mode = MODE_W'(a);
			default:   begin ev.fw = coord_t'(a); ev.fh = coord_t'(b); end
		endcase
		return ev;
	endfunction

	// Mostly centre events in tracking mode, some aimed at the deadband edge
	function automatic event_t rand_event();
		event_t ev;
		int r, d;
		ev = mk_event(OP_CENTER, $urandom_range(0, 4095), $urandom_range(0, 4095));
		r = $urandom_range(0, 99);
		if (r < 62) begin
			if ($urandom_range(0, 3) == 0) begin
				d = int'(db_q) + 2;
				ev.pos_x = clip_coord(int'(frame_w) / 2 + int'($urandom_range(0, 2 * d)) - d);
				ev.pos_y = clip_coord(int'(frame_h) / 2 + int'($urandom_range(0, 2 * d)) - d);
			end
		end else if (r < 74) begin
			ev.op = OP_ANGLE;
			if ($urandom_range(0, 4) != 0) begin
				ev.pan = angle_t'($urandom_range(0, ANGLE_LIMIT));
				ev.tilt = angle_t'($urandom_range(0, ANGLE_LIMIT));
			end
		end else if (r < 86) begin
			ev.op = OP_MODE;
			if ($urandom_range(0, 3) != 0)
				ev.mode = TRACK_MODE;
		end else begin
			ev.op = OP_FRAME;
			if ($urandom_range(0, 2) == 0) begin
				ev.fw = coord_t'($urandom_range(1, 64));
				ev.fh = coord_t'($urandom_range(1, 64));
			end else begin
				ev.fw = coord_t'($urandom_range(1, 4095));
				ev.fh = coord_t'($urandom_range(1, 4095));
			end
			if ($urandom_range(0, 9) == 0)
				ev.fw = '0;
			else if ($urandom_range(0, 9) == 0)
				ev.fh = '0;
		end
		return ev;
	endfunction

	task automatic send_event(input event_t ev);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.operation    <= ev.op;
		item_ch.pos_x        <= ev.pos_x;
		item_ch.pos_y        <= ev.pos_y;
		item_ch.pan_report   <= ev.pan;
		item_ch.tilt_report  <= ev.tilt;
		item_ch.new_mode     <= ev.mode;
		item_ch.frame_width  <= ev.fw;
		item_ch.frame_height <= ev.fh;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		track_event(ev);
	endtask

	// Drop valid, wait for every command, then let the pipeline run dry
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (target_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * idx);
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (idx == REG_DEADBAND)
			db_q = val[DB_W-1:0];
		else
			gain_q[idx] = val;
	endtask

	task automatic apply_config();
		for (int i = 0; i < 7; i++)
			apb_write(i, cfg_stage[i]);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_event_decode();
		send_event(mk_event(OP_CENTER, 100, 100));
		send_event(mk_event(OP_MODE, 1, 0));
		send_event(mk_event(OP_CENTER, 10, 4000));
		send_event(mk_event(OP_FRAME, 640, 0));
		send_event(mk_event(OP_CENTER, 0, 0));
		send_event(mk_event(OP_FRAME, 640, 480));
		send_event(mk_event(OP_CENTER, 320, 240));
		send_event(mk_event(OP_CENTER, 322, 238));
		send_event(mk_event(OP_CENTER, 325, 240));
		send_event(mk_event(OP_CENTER, 0, 0));
		send_event(mk_event(OP_CENTER, 4095, 4095));
		send_event(mk_event(OP_ANGLE, 360, 0));
		send_event(mk_event(OP_CENTER, 639, 0));
		send_event(mk_event(OP_ANGLE, 511, 400));
		send_event(mk_event(OP_CENTER, 0, 479));
		send_event(mk_event(OP_MODE, 2, 0));
		send_event(mk_event(OP_CENTER, 0, 0));
		send_event(mk_event(OP_MODE, 255, 0));
		send_event(mk_event(OP_MODE, 1, 0));
		send_event(mk_event(OP_FRAME, 4095, 4095));
		send_event(mk_event(OP_CENTER, 4095, 0));
		send_event(mk_event(OP_FRAME, 1, 1));
		send_event(mk_event(OP_CENTER, 0, 0));
		send_event(mk_event(OP_CENTER, 4095, 4095));
		drain();
	endtask

	task automatic test_register_extremes();
		for (int set = 0; set < 3; set++) begin
			for (int i = 0; i < 6; i++)
				case (set)
					0: cfg_stage[i] = 16'h7fff;
					1: cfg_stage[i] = 16'h8000;
					default: cfg_stage[i] = (i % 2 == 0) ? 16'h8000 : 16'h7fff;
				endcase
			// zero never centres, full width always centres
			cfg_stage[REG_DEADBAND] = (set == 0) ? 16'h0000 : (set == 1) ? 16'h0fff : 16'h0001;
			apply_config();
			send_event(mk_event(OP_MODE, 1, 0));
			send_event(mk_event(OP_FRAME, 640, 480));
			for (int n = 0; n < 20; n++)
				send_event(rand_event());
			drain();
		end
	endtask

	task automatic test_random_traffic();
		int v;
		for (int phase = 0; phase < 6; phase++) begin
			for (int i = 0; i < 6; i++) begin
				v = int'($urandom_range(0, 4096)) - 2048;
				cfg_stage[i] = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(v);
			end
			cfg_stage[REG_DEADBAND] = ($urandom_range(0, 5) == 0) ?
				16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 40));
			apply_config();
			for (int n = 0; n < 105; n++) begin
				if ($urandom_range(0, 29) == 0)
					src_steady = !src_steady;
				send_event(rand_event());
			end
			drain();
		end
	endtask

	// Result sink: hold ready low for a random stall before each beat
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				snk_steady = !snk_steady;
			stall = snk_steady ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cmd_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (target_fifo.size() == 0) begin
				$display("%0t unexpected command: expected none, actual pan %0d tilt %0d",
					$time, result_ch.pan_command, result_ch.tilt_command);
				mismatches++;
			end else begin
				want = target_fifo.pop_front();
				if (result_ch.pan_command !== want.pan) begin
					$display("%0t pan_command: expected %0d, actual %0d",
						$time, want.pan, result_ch.pan_command);
					mismatches++;
				end
				if (result_ch.tilt_command !== want.tilt) begin
					$display("%0t tilt_command: expected %0d, actual %0d",
						$time, want.tilt, result_ch.tilt_command);
					mismatches++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_CENTER;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.pan_report = '0;
		item_ch.tilt_report = '0;
		item_ch.new_mode = '0;
		item_ch.frame_width = '0;
		item_ch.frame_height = '0;
		mismatches = 0;
		cycle_count = 0;
		src_steady = 1'b0;
		snk_steady = 1'b0;
		gain_q[REG_KP_PAN] = 16'sd410;
		gain_q[REG_KI_PAN] = '0;
		gain_q[REG_KD_PAN] = '0;
		gain_q[REG_KP_TILT] = 16'sd410;
		gain_q[REG_KI_TILT] = '0;
		gain_q[REG_KD_TILT] = '0;
		db_q = DB_W'(5);
		mode_q = '0;
		pan_pos = angle_t'(ANGLE_RESET);
		tilt_pos = angle_t'(ANGLE_RESET);
		frame_w = '0;
		frame_h = '0;
		clear_pid();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_event_decode();
		test_register_extremes();
		test_random_traffic();

		if (mismatches == 0 && target_fifo.size() == 0)
			$display("pan_tilt_tracking_pid_unit: match");
		else
			$display("pan_tilt_tracking_pid_unit: mismatch");
		$finish;
	end

endmodule
